>>> rtl/core/nfc_rfp_pkg.sv
// ----------------------------------------------------------------------------
// NFC response frame parser package
// Shared types, status codes and constants for the parser front, the op queue
// and the result back end.
// ----------------------------------------------------------------------------
package nfc_rfp_pkg;

   // frame constants
   localparam logic [7:0] START_LO_BYTE = 8'h00;
   localparam logic [7:0] START_HI_BYTE = 8'hFF;
   localparam logic [7:0] DIR_TO_HOST   = 8'hD5;

   // final status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOSTART = 3'd1;
   localparam logic [2:0] ST_LCS     = 3'd2;
   localparam logic [2:0] ST_RESP    = 3'd3;
   localparam logic [2:0] ST_SIZE    = 3'd4;
   localparam logic [2:0] ST_TRUNC   = 3'd5;
   localparam logic [2:0] ST_DCS     = 3'd6;

   // result item kinds
   localparam logic KIND_BODY   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // register map, indexed by paddr[2]
   localparam int  CSR_ADDR_W      = 3;
   localparam logic REG_EXP_CMD    = 1'b0;
   localparam logic REG_BODY_CAP   = 1'b1;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       window_end;
   } nfc_rfp_req_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] body_byte;
      logic [2:0] status_code;
      logic [7:0] body_length;
      logic       is_last;
   } nfc_rfp_rsp_type;

   typedef struct packed {
      logic [7:0] expected_command;
      logic [7:0] body_capacity;
   } nfc_rfp_cfg_type;

   // one queued op: an optional body byte followed by an optional status
   typedef struct packed {
      logic       body_valid;
      logic [7:0] body_byte;
      logic       status_valid;
      logic [2:0] status_code;
      logic [7:0] body_length;
   } nfc_rfp_op_type;

endpackage

>>> rtl/core/nfc_rfp_front.sv
// ----------------------------------------------------------------------------
// NFC response frame parser front
// Per-byte frame parser: start code search, header checks, body checksum and
// the end-of-window verdict. Emits one op per byte that produces results.
// ----------------------------------------------------------------------------
module nfc_rfp_front
   import nfc_rfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  nfc_rfp_req_type req,
   input  nfc_rfp_cfg_type cfg,
   output logic            op_push,
   output nfc_rfp_op_type  op
);

   typedef enum logic [2:0] {
      PH_SEARCH, PH_LEN, PH_LCS, PH_TFI, PH_CMD, PH_BODY, PH_DCS, PH_DONE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       last_zero_ff, last_zero_in;
   logic [7:0] frame_len_ff, frame_len_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] count_ff, count_in;
   logic       sent_ff, sent_in;
   logic [2:0] held_ff, held_in;

   logic [7:0] b;
   logic [7:0] echo;
   logic [7:0] payload_len;
   logic [7:0] lcs_sum;
   logic [7:0] dcs_sum;
   logic [7:0] next_sum;
   logic [7:0] next_count;
   logic [2:0] held_tmp;
   logic [2:0] final_st;

   assign b           = req.data_byte;
   assign echo        = cfg.expected_command + 8'd1;
   assign payload_len = frame_len_ff - 8'd2;
   assign lcs_sum     = frame_len_ff + b;
   assign dcs_sum     = sum_ff + b;
   assign next_sum    = sum_ff + b;
   assign next_count  = count_ff + 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      last_zero_in = last_zero_ff;
      frame_len_in = frame_len_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      sent_in      = sent_ff;
      held_in      = held_ff;
      held_tmp     = held_ff;
      final_st     = ST_OK;
      op           = '0;
      op_push      = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (last_zero_ff && b == START_HI_BYTE) phase_in = PH_LEN;
               last_zero_in = (b == START_LO_BYTE);
            end
            PH_LEN: begin
               frame_len_in = b;
               phase_in     = PH_LCS;
            end
            PH_LCS: begin
               if (lcs_sum != 8'd0) begin
                  if (held_ff == ST_OK) held_in = ST_LCS;
               end else if (frame_len_ff < 8'd2) begin
                  if (held_ff == ST_OK) held_in = ST_RESP;
               end
               phase_in = PH_TFI;
            end
            PH_TFI: begin
               if (b != DIR_TO_HOST && held_ff == ST_OK) held_in = ST_RESP;
               phase_in = PH_CMD;
            end
            PH_CMD: begin
               if (b != echo && held_tmp == ST_OK) held_tmp = ST_RESP;
               if (held_tmp != ST_OK) begin
                  held_in  = held_tmp;
                  sent_in  = 1'b1;
                  phase_in = PH_DONE;
               end else if (cfg.body_capacity != 8'd0 && payload_len > cfg.body_capacity) begin
                  held_in  = ST_SIZE;
                  sent_in  = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  sum_in   = DIR_TO_HOST + b;
                  count_in = 8'd0;
                  phase_in = (frame_len_ff == 8'd2) ? PH_DCS : PH_BODY;
               end
            end
            PH_BODY: begin
               sum_in        = next_sum;
               count_in      = next_count;
               op.body_valid = (cfg.body_capacity != 8'd0);
               op.body_byte  = b;
               if (next_count == payload_len) phase_in = PH_DCS;
            end
            PH_DCS: begin
               held_in  = (dcs_sum == 8'd0) ? ST_OK : ST_DCS;
               sent_in  = 1'b1;
               phase_in = PH_DONE;
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase

         if (req.window_end) begin
            if (sent_in)
               final_st = held_in;
            else if (phase_in == PH_BODY || phase_in == PH_DCS)
               final_st = ST_TRUNC;
            else
               final_st = ST_NOSTART;
            op.status_valid = 1'b1;
            op.status_code  = final_st;
            op.body_length  = (final_st == ST_OK && cfg.body_capacity != 8'd0) ?
                              (frame_len_in - 8'd2) : 8'd0;
            // window closes: start over
            phase_in     = PH_SEARCH;
            last_zero_in = 1'b0;
            frame_len_in = 8'd0;
            sum_in       = 8'd0;
            count_in     = 8'd0;
            sent_in      = 1'b0;
            held_in      = ST_OK;
         end
         op_push = op.body_valid | op.status_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         last_zero_ff <= 1'b0;
         frame_len_ff <= 8'd0;
         sum_ff       <= 8'd0;
         count_ff     <= 8'd0;
         sent_ff      <= 1'b0;
         held_ff      <= ST_OK;
      end else begin
         phase_ff     <= phase_in;
         last_zero_ff <= last_zero_in;
         frame_len_ff <= frame_len_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         sent_ff      <= sent_in;
         held_ff      <= held_in;
      end
   end

   a_sent_means_done: assert property (@(posedge clock) disable iff (reset)
      sent_ff |-> phase_ff == PH_DONE)
      else $error("verdict fixed outside done phase");

   a_body_count_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> count_ff < payload_len)
      else $error("body count ran past frame length");

   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      op_push |-> accept)
      else $error("op pushed without an accepted byte");

endmodule

>>> rtl/core/nfc_rfp_fifo.sv
// ----------------------------------------------------------------------------
// NFC response frame parser op queue
// Small register queue between the parser front and the result back end.
// ----------------------------------------------------------------------------
module nfc_rfp_fifo
   import nfc_rfp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_en,
   input  nfc_rfp_op_type wr_data,
   input  logic           rd_en,
   output nfc_rfp_op_type rd_data,
   output logic           full,
   output logic           empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   nfc_rfp_op_type   entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign rd_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (rd_en) rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      else if (!wr_en && rd_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) entries_ff[wr_ptr_ff] <= wr_data;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count overflow");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("write into full queue");

   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("read from empty queue");

endmodule

>>> rtl/core/nfc_rfp_back.sv
// ----------------------------------------------------------------------------
// NFC response frame parser back end
// Expands each queued op into its body beat and/or status beat and hands
// them to the result channel in order.
// ----------------------------------------------------------------------------
module nfc_rfp_back
   import nfc_rfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  nfc_rfp_op_type  head,
   input  logic            q_empty,
   output logic            q_pop,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output nfc_rfp_rsp_type rsp_payload
);

   logic body_done_ff, body_done_in;
   logic show_body;
   logic take;

   // body beat goes first unless already delivered for this op
   assign show_body = head.body_valid & ~body_done_ff;
   assign rsp_empty = q_empty;
   assign take      = rsp_pop & ~q_empty;

   always_comb begin
      rsp_payload = '0;
      if (show_body) begin
         rsp_payload.item_kind = KIND_BODY;
         rsp_payload.body_byte = head.body_byte;
      end else begin
         rsp_payload.item_kind   = KIND_STATUS;
         rsp_payload.status_code = head.status_code;
         rsp_payload.body_length = head.body_length;
         rsp_payload.is_last     = 1'b1;
      end
   end

   always_comb begin
      q_pop        = 1'b0;
      body_done_in = body_done_ff;
      if (take) begin
         if (show_body && head.status_valid) begin
            body_done_in = 1'b1;
         end else begin
            q_pop        = 1'b1;
            body_done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         body_done_ff <= 1'b0;
      end else begin
         body_done_ff <= body_done_in;
      end
   end

   a_body_done_head: assert property (@(posedge clock) disable iff (reset)
      body_done_ff |-> !q_empty && head.body_valid && head.status_valid)
      else $error("body marked done without a two-beat op at head");

   a_pop_follows_take: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> take)
      else $error("op dropped without a result beat");

   a_split_then_status: assert property (@(posedge clock) disable iff (reset)
      take && show_body && head.status_valid |=> !show_body)
      else $error("status beat not next after split body beat");

endmodule

>>> rtl/core/nfc_response_frame_parser.sv
// ----------------------------------------------------------------------------
// NFC response frame parser
// Parses the bytes of one bus read window into body beats and a final status.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one raw byte per beat (req_push / req_full), window_end set on the
//   window's last byte. Output: body beats (item_kind 0) stream out as they
//   arrive, then exactly one status beat (item_kind 1, is_last 1) per window.
//   Body beats are sent before the data checksum is known; drop them when the
//   status is not ok.
//   Throughput: one byte per cycle while req_full is low. A window-end byte
//   that also carries a body byte yields two result beats, drained one per
//   cycle by the back end while rsp_pop is high. Each result passes through
//   the op queue (QUEUE_DEPTH entries), which sets how long input flows while
//   rsp_pop is held low; once it fills, req_full stays high until the oldest
//   entry is fully drained (one beat, or two when a body byte ends a window).
//   Reset (synchronous) clears the parser, the queue and both CSRs to zero.
//   CSRs: expected_command at 0x0, body_capacity at 0x4; write only while idle.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser
   import nfc_rfp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  nfc_rfp_req_type       req_payload,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output nfc_rfp_rsp_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   nfc_rfp_cfg_type cfg_ff, cfg_in;
   logic            csr_wr;
   logic            accept;
   logic            op_push;
   nfc_rfp_op_type  op;
   nfc_rfp_op_type  head;
   logic            q_full;
   logic            q_empty;
   logic            q_pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_EXP_CMD:  cfg_in.expected_command = csr_pwdata[7:0];
            REG_BODY_CAP: cfg_in.body_capacity    = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_EXP_CMD:  csr_prdata = {24'd0, cfg_ff.expected_command};
         REG_BODY_CAP: csr_prdata = {24'd0, cfg_ff.body_capacity};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;

   nfc_rfp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_payload),
      .cfg     (cfg_ff),
      .op_push (op_push),
      .op      (op)
   );

   nfc_rfp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (op_push),
      .wr_data (op),
      .rd_en   (q_pop),
      .rd_data (head),
      .full    (q_full),
      .empty   (q_empty)
   );

   nfc_rfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> dv/nfc_rfp_frame_check.sv
// ----------------------------------------------------------------------------
// NFC response frame parser checker
// Watches the byte, result and CSR ports of the parser, predicts the body and
// status beats that each accepted byte causes, and compares every popped beat
// field by field against the oldest prediction. Also checks CSR read-back.
// ----------------------------------------------------------------------------
module nfc_rfp_frame_check
   import nfc_rfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  nfc_rfp_req_type       req_payload,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  nfc_rfp_rsp_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic [31:0]           csr_prdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    beats_pending,
   output int                    beats_checked,
   output int                    body_beats_seen,
   output logic [6:0]            status_seen
);

   typedef enum logic [2:0] {
      HUNT_START,
      TAKE_LEN,
      TAKE_LCS,
      TAKE_DIR,
      TAKE_CMD,
      TAKE_BODY,
      TAKE_DCS,
      SETTLED
   } parse_state_e;

   // shadow of the CSRs
   logic [7:0]      cmd_sent;
   logic [7:0]      body_cap;

   // parser shadow state
   parse_state_e    parse_state;
   logic            prev_zero;
   logic [7:0]      frame_len;
   logic [7:0]      check_sum;
   logic [7:0]      body_taken;
   logic            verdict_fixed;
   logic [2:0]      verdict;

   nfc_rfp_rsp_type pending_beats[$];

   assign beats_pending = pending_beats.size();

   task automatic clear_frame();
      parse_state   = HUNT_START;
      prev_zero     = 1'b0;
      frame_len     = '0;
      check_sum     = '0;
      body_taken    = '0;
      verdict_fixed = 1'b0;
      verdict       = ST_OK;
   endtask

   task automatic settle(input logic [2:0] code);
      verdict       = code;
      verdict_fixed = 1'b1;
      parse_state   = SETTLED;
   endtask

   // expected beats for one accepted byte
   task automatic parse_frame_byte(input logic [7:0] b, input logic last_byte);
      nfc_rfp_rsp_type beat;
      logic [2:0]      code;
      case (parse_state)
         HUNT_START: begin
            if (prev_zero && b == START_HI_BYTE) parse_state = TAKE_LEN;
            prev_zero = (b == START_LO_BYTE);
         end
         TAKE_LEN: begin
            frame_len   = b;
            parse_state = TAKE_LCS;
         end
         TAKE_LCS: begin
            if (8'(frame_len + b) != 8'd0) begin
               if (verdict == ST_OK) verdict = ST_LCS;
            end else if (frame_len < 8'd2) begin
               if (verdict == ST_OK) verdict = ST_RESP;
            end
            parse_state = TAKE_DIR;
         end
         TAKE_DIR: begin
            if (b != DIR_TO_HOST && verdict == ST_OK) verdict = ST_RESP;
            parse_state = TAKE_CMD;
         end
         TAKE_CMD: begin
            if (b != 8'(cmd_sent + 8'd1) && verdict == ST_OK) verdict = ST_RESP;
            if (verdict != ST_OK) begin
               settle(verdict);
            end else if (body_cap != 0 && 8'(frame_len - 8'd2) > body_cap) begin
               settle(ST_SIZE);
            end else begin
               check_sum   = 8'(DIR_TO_HOST + b);
               body_taken  = '0;
               parse_state = (frame_len == 8'd2) ? TAKE_DCS : TAKE_BODY;
            end
         end
         TAKE_BODY: begin
            check_sum  = 8'(check_sum + b);
            body_taken = 8'(body_taken + 8'd1);
            if (body_cap != 0) begin
               beat           = '0;
               beat.item_kind = KIND_BODY;
               beat.body_byte = b;
               pending_beats.push_back(beat);
            end
            if (body_taken == 8'(frame_len - 8'd2)) parse_state = TAKE_DCS;
         end
         TAKE_DCS: settle((8'(check_sum + b) == 8'd0) ? ST_OK : ST_DCS);
         default: ;
      endcase

      if (last_byte) begin
         if (verdict_fixed)
            code = verdict;
         else if (parse_state <= TAKE_CMD)
            code = ST_NOSTART;
         else
            code = ST_TRUNC;
         beat             = '0;
         beat.item_kind   = KIND_STATUS;
         beat.status_code = code;
         beat.is_last     = 1'b1;
         if (code == ST_OK && body_cap != 0) beat.body_length = 8'(frame_len - 8'd2);
         pending_beats.push_back(beat);
         clear_frame();
      end
   endtask

   always @(posedge clock) begin
      nfc_rfp_rsp_type want;
      if (reset) begin
         cmd_sent        = '0;
         body_cap        = '0;
         mismatch_count  = 0;
         beats_checked   = 0;
         body_beats_seen = 0;
         status_seen     = '0;
         pending_beats.delete();
         clear_frame();
      end else begin
         // results first: a beat can never come from a byte taken at this edge
         if (rsp_pop && !rsp_empty) begin
            if (pending_beats.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result beat: kind %0d byte %02h status %0d len %0d last %0d",
                        $time, rsp_payload.item_kind, rsp_payload.body_byte,
                        rsp_payload.status_code, rsp_payload.body_length, rsp_payload.is_last);
            end else begin
               want = pending_beats.pop_front();
               beats_checked++;
               if (want.item_kind == KIND_BODY) body_beats_seen++;
               else status_seen[want.status_code] = 1'b1;
               if (rsp_payload.item_kind   !== want.item_kind   ||
                   rsp_payload.body_byte   !== want.body_byte   ||
                   rsp_payload.status_code !== want.status_code ||
                   rsp_payload.body_length !== want.body_length ||
                   rsp_payload.is_last     !== want.is_last) begin
                  mismatch_count++;
                  $display("%0t: result beat mismatch: expected kind %0d byte %02h status %0d len %0d last %0d",
                           $time, want.item_kind, want.body_byte, want.status_code,
                           want.body_length, want.is_last);
                  $display("%0t:                         got kind %0d byte %02h status %0d len %0d last %0d",
                           $time, rsp_payload.item_kind, rsp_payload.body_byte,
                           rsp_payload.status_code, rsp_payload.body_length,
                           rsp_payload.is_last);
               end
            end
         end

         if (req_push && !req_full) parse_frame_byte(req_payload.data_byte, req_payload.window_end);

         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_EXP_CMD) cmd_sent = csr_pwdata[7:0];
               else body_cap = csr_pwdata[7:0];
            end else if (csr_prdata !== 32'((csr_paddr[2] == REG_EXP_CMD) ? cmd_sent : body_cap)) begin
               mismatch_count++;
               $display("%0t: CSR read at %0h: expected %08h, got %08h", $time, csr_paddr,
                        32'((csr_paddr[2] == REG_EXP_CMD) ? cmd_sent : body_cap), csr_prdata);
            end
         end
      end
   end

endmodule

>>> dv/nfc_response_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// NFC response frame parser testbench
// Feeds read windows of raw bytes (clean frames, noise, header, checksum,
// echo and size faults, cut-short windows) under a range of command and
// capacity settings, with random idles on both channels and a long result
// stall. The frame checker predicts and compares; this top makes stimulus.
// ----------------------------------------------------------------------------
module nfc_response_frame_parser_tb;
   import nfc_rfp_pkg::*;

   localparam int RANDOM_BEATS   = 850;
   localparam int WINDOWS_PER_CFG = 8;
   localparam int HOLD_CYCLES    = 80;
   localparam int SETTLE_CYCLES  = 6;
   localparam int CYCLE_LIMIT    = 400000;

   typedef enum int {
      FRAME_GOOD,
      FRAME_NOISE,
      FRAME_BAD_LCS,
      FRAME_SHORT_LEN,
      FRAME_BAD_DIR,
      FRAME_BAD_ECHO,
      FRAME_BAD_DCS,
      FRAME_OVERSIZE
   } frame_mode_e;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push;
   logic                  req_full;
   nfc_rfp_req_type       req_payload;
   logic                  rsp_empty;
   logic                  rsp_pop;
   nfc_rfp_rsp_type       rsp_payload;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int                    mismatch_count;
   int                    beats_pending;
   int                    beats_checked;
   int                    body_beats_seen;
   logic [6:0]            status_seen;

   logic [7:0]            window_bytes[$];
   logic [7:0]            cmd_sent;
   logic [7:0]            body_cap;
   int                    beats_sent;
   int                    windows_sent;
   int                    csr_writes;
   int unsigned           cycle_count;
   bit                    gapless;
   bit                    hold_rsp_req = 1'b0;
   bit                    holding = 1'b0;

   always #10 clock = ~clock;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("nfc_response_frame_parser_tb NOT OK");
         $finish;
      end
   end

   nfc_response_frame_parser u_top (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   nfc_rfp_frame_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_payload     (req_payload),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_payload     (rsp_payload),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .beats_pending   (beats_pending),
      .beats_checked   (beats_checked),
      .body_beats_seen (body_beats_seen),
      .status_seen     (status_seen)
   );

   // mostly short idles, now and then a long one
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // result side: random pops and stalls, plus a counted hold-off on request
   initial begin
      int n;
      int held;
      rsp_pop <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp_req) begin
            rsp_pop <= 1'b0;
            holding = 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
            holding      = 1'b0;
            hold_rsp_req = 1'b0;
         end else if ($urandom_range(0, 1) == 0) begin
            rsp_pop <= 1'b1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
            repeat (n) @(posedge clock);
         end else begin
            rsp_pop <= 1'b0;
            n = 1 + idle_cycles();
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic last_byte);
      int gap;
      req_payload <= '{data_byte: b, window_end: last_byte};
      req_push    <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      beats_sent++;
      gap = gapless ? 0 : idle_cycles();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_window();
      for (int i = 0; i < window_bytes.size(); i++)
         send_beat(window_bytes[i], i == window_bytes.size() - 1);
      windows_sent++;
   endtask

   task automatic build_window(input frame_mode_e mode, input int payload_len, input bit cut);
      int         len_field;
      int         keep;
      logic [7:0] echo;
      logic [7:0] b;
      logic [7:0] sum;
      window_bytes.delete();
      // lead-in never holds FF, so it cannot start a frame early
      repeat ($urandom_range(0, 3))
         window_bytes.push_back(($urandom_range(0, 3) == 0) ? START_LO_BYTE
                                                             : 8'($urandom_range(1, 254)));
      if (mode == FRAME_NOISE) begin
         repeat ($urandom_range(1, 10)) window_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         len_field = (mode == FRAME_SHORT_LEN) ? $urandom_range(0, 1) : payload_len + 2;
         window_bytes.push_back(START_LO_BYTE);
         window_bytes.push_back(START_HI_BYTE);
         window_bytes.push_back(8'(len_field));
         window_bytes.push_back((mode == FRAME_BAD_LCS) ? 8'(-len_field + $urandom_range(1, 255))
                                                        : 8'(-len_field));
         window_bytes.push_back((mode == FRAME_BAD_DIR) ? DIR_TO_HOST ^ 8'($urandom_range(1, 255))
                                                        : DIR_TO_HOST);
         echo = 8'(cmd_sent + 8'd1);
         if (mode == FRAME_BAD_ECHO) echo = 8'(echo + $urandom_range(1, 255));
         window_bytes.push_back(echo);
         sum = 8'(DIR_TO_HOST + echo);
         repeat (payload_len) begin
            b = 8'($urandom_range(0, 255));
            window_bytes.push_back(b);
            sum = 8'(sum + b);
         end
         window_bytes.push_back((mode == FRAME_BAD_DCS) ? 8'(-sum + $urandom_range(1, 255))
                                                        : 8'(-sum));
      end
      repeat ($urandom_range(0, 2)) window_bytes.push_back(8'($urandom_range(0, 255)));
      if (cut) begin
         keep = $urandom_range(1, window_bytes.size());
         while (window_bytes.size() > keep) void'(window_bytes.pop_back());
      end
   endtask

   task automatic csr_write(input logic reg_sel, input logic [7:0] value);
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= 32'(value);
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      // read it back; the checker compares prdata
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (reg_sel == REG_EXP_CMD) cmd_sent = value;
      else body_cap = value;
      csr_writes++;
   endtask

   // wait until every predicted beat is out and the parser has gone quiet
   task automatic drain();
      req_push <= 1'b0;
      // let the checker log the last accepted byte before looking at the count
      @(posedge clock);
      while (beats_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] cmd, input logic [7:0] cap);
      drain();
      csr_write(REG_EXP_CMD, cmd);
      csr_write(REG_BODY_CAP, cap);
   endtask

   // hold the result side off while windows go in back to back
   task automatic fill_queue();
      req_push     <= 1'b0;
      hold_rsp_req = 1'b1;
      while (!holding) @(posedge clock);
      gapless = 1'b1;
      repeat (4) begin
         build_window(FRAME_GOOD, (body_cap < 8) ? body_cap : $urandom_range(2, 8), 1'b0);
         send_window();
      end
      gapless = 1'b0;
   endtask

   initial begin
      int          plan;
      int          r;
      int          payload_len;
      bit          filled;
      frame_mode_e mode;
      req_push    <= 1'b0;
      req_payload <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      cmd_sent     = '0;
      body_cap     = '0;
      gapless      = 1'b0;
      filled       = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // directed windows at reset settings: command 00, capacity zero
      window_bytes = '{8'h00};
      send_window();
      // header cut short: still counts as no start
      window_bytes = '{8'h00, 8'hFF, 8'h05};
      send_window();
      // empty body, capacity zero, ends on the data checksum
      window_bytes = '{8'h00, 8'hFF, 8'h02, 8'hFE, 8'hD5, 8'h01, 8'h2A};
      send_window();
      // length under two with a good length checksum
      window_bytes = '{8'h00, 8'hFF, 8'h01, 8'hFF, 8'hD5, 8'h01};
      send_window();
      // bad length checksum outranks the rest
      window_bytes = '{8'h00, 8'hFF, 8'h03, 8'hFC, 8'h11, 8'h07};
      send_window();
      // echo wraps to 00; window ends on a body byte: body beat plus truncated
      set_config(8'hFF, 8'hFF);
      window_bytes = '{8'h00, 8'hFF, 8'h03, 8'hFD, 8'hD5, 8'h00, 8'hFF};
      send_window();
      // largest body
      build_window(FRAME_GOOD, 253, 1'b0);
      send_window();

      plan = 0;
      while (beats_sent < RANDOM_BEATS) begin
         if (windows_sent % WINDOWS_PER_CFG == 0) begin
            case (plan)
               0:       set_config(8'h00, 8'd1);
               1:       set_config(8'($urandom_range(0, 255)), 8'd0);
               2:       set_config(8'($urandom_range(0, 255)), 8'($urandom_range(2, 40)));
               3:       set_config(8'hFF, 8'd253);
               4:       set_config(8'h00, 8'hFF);
               default: begin
                  r = $urandom_range(0, 3);
                  set_config(8'($urandom_range(0, 255)),
                             (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : 8'($urandom_range(1, 40)));
               end
            endcase
            plan++;
         end
         if (body_cap != 0 && (!filled || $urandom_range(0, 29) == 0)) begin
            fill_queue();
            filled = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 55)      mode = FRAME_GOOD;
         else if (r < 62) mode = FRAME_NOISE;
         else if (r < 68) mode = FRAME_BAD_LCS;
         else if (r < 73) mode = FRAME_SHORT_LEN;
         else if (r < 78) mode = FRAME_BAD_DIR;
         else if (r < 83) mode = FRAME_BAD_ECHO;
         else if (r < 91) mode = FRAME_BAD_DCS;
         else             mode = FRAME_OVERSIZE;
         r = $urandom_range(0, 59);
         if (r == 0)     payload_len = $urandom_range(150, 253);
         else if (r < 10) payload_len = $urandom_range(9, 40);
         else            payload_len = $urandom_range(0, 8);
         if (mode == FRAME_OVERSIZE && body_cap != 0 && body_cap < 253)
            payload_len = $urandom_range(body_cap + 1,
                                         (body_cap + 8 > 253) ? 253 : body_cap + 8);
         gapless = ($urandom_range(0, 5) == 0);
         build_window(mode, payload_len, $urandom_range(0, 7) == 0);
         send_window();
         gapless = 1'b0;
      end

      drain();
      $display("Covered %0d input beats in %0d windows with %0d CSR writes.",
               beats_sent, windows_sent, csr_writes);
      $display("Checked %0d result beats (%0d body); status codes seen %b.",
               beats_checked, body_beats_seen, status_seen);
      if (mismatch_count == 0)
         $display("nfc_response_frame_parser_tb OK");
      else
         $display("nfc_response_frame_parser_tb NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/nfc_rfp_pkg.sv
rtl/core/nfc_rfp_front.sv
rtl/core/nfc_rfp_fifo.sv
rtl/core/nfc_rfp_back.sv
rtl/core/nfc_response_frame_parser.sv
dv/nfc_rfp_frame_check.sv
dv/nfc_response_frame_parser_tb.sv
